// ===== rtl/core/scd_pkg.sv =====
// Shared types, constants and the shape-code lookup for the scanline digit classifier.
// No dependencies; imported by scd_run_counter and scanline_digit_classifier_core.

package scd_pkg;

    // Run counts saturate at seven, so three bits are enough.
    localparam int RUN_W = 3;
    typedef logic [RUN_W-1:0] run_cnt_t;
    localparam run_cnt_t RUN_MAX = run_cnt_t'(7);

    // Stream word widths.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 8;
    localparam int COORD_W   = 8;
    localparam int DIM_W     = 9;
    localparam int CHAR_W    = 7;

    // Glyph dimensions are clamped to this before sample positions are computed.
    localparam logic [DIM_W-1:0] MAX_DIM = 9'd256;
    localparam logic [7:0]       WHITE   = 8'd255;

    // Reciprocal constants: floor(3h/10) = (h*615) >> 11 and
    // floor(66h/100) = (h*346038) >> 19, exact for every h up to 256.
    localparam int R1_MUL  = 615;
    localparam int R1_SH   = 11;
    localparam int R1_PW   = 19;
    localparam int R2_MUL  = 346038;
    localparam int R2_SH   = 19;
    localparam int R2_PW   = 28;

    // Shape codes {column runs, upper row runs, lower row runs}.
    localparam logic [8:0] CODE_X = {3'd1, 3'd2, 3'd2};
    localparam logic [8:0] CODE_0 = {3'd2, 3'd2, 3'd2};
    localparam logic [8:0] CODE_1 = {3'd1, 3'd1, 3'd1};
    localparam logic [8:0] CODE_2 = {3'd3, 3'd1, 3'd1};
    localparam logic [8:0] CODE_3 = {3'd3, 3'd0, 3'd0};
    localparam logic [8:0] CODE_4 = {3'd2, 3'd2, 3'd1};
    localparam logic [8:0] CODE_5 = {3'd3, 3'd3, 3'd3};
    localparam logic [8:0] CODE_6 = {3'd3, 3'd1, 3'd2};
    localparam logic [8:0] CODE_7 = {3'd2, 3'd1, 3'd1};
    localparam logic [8:0] CODE_8 = {3'd3, 3'd2, 3'd2};
    localparam logic [8:0] CODE_9 = {3'd3, 3'd2, 3'd1};

    // ASCII results.
    localparam logic [CHAR_W-1:0] CH_NONE = 7'd0;
    localparam logic [CHAR_W-1:0] CH_X    = 7'd88;
    localparam logic [CHAR_W-1:0] CH_ZERO = 7'd48;

    // Control word that the core hands to each line run counter.
    typedef struct packed {
        logic step;        // an item is processed this cycle
        logic hit;         // the item lies on this counter's sample line
        logic white;       // the pixel is white
        logic line_start;  // the pixel sits at index 0 of its line
        logic clear;       // last pixel of the glyph: return to reset state
    } run_ctrl_t;

    // Map a shape code to its character, CH_NONE if unknown.
    function automatic logic [CHAR_W-1:0] scd_lookup(input logic [8:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            CODE_X:  ch = CH_X;
            CODE_0:  ch = CH_ZERO;
            CODE_1:  ch = CH_ZERO + 7'd1;
            CODE_2:  ch = CH_ZERO + 7'd2;
            CODE_3:  ch = CH_ZERO + 7'd3;
            CODE_4:  ch = CH_ZERO + 7'd4;
            CODE_5:  ch = CH_ZERO + 7'd5;
            CODE_6:  ch = CH_ZERO + 7'd6;
            CODE_7:  ch = CH_ZERO + 7'd7;
            CODE_8:  ch = CH_ZERO + 7'd8;
            CODE_9:  ch = CH_ZERO + 7'd9;
            default: ch = CH_NONE;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/scd_run_counter.sv =====
// Saturating white-run counter for one sample line of the glyph.
// Depends on scd_pkg for run_cnt_t, RUN_MAX and run_ctrl_t.

module scd_run_counter
    import scd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  run_ctrl_t ctrl,
    output run_cnt_t  runs_next
);

    run_cnt_t runs_reg;
    logic     prev_white_reg;
    logic     prev_white_next;

    // A run begins on a white pixel at the line start or after a non-white pixel.
    always_comb begin
        runs_next       = runs_reg;
        prev_white_next = prev_white_reg;
        if (ctrl.hit) begin
            if (ctrl.white && (ctrl.line_start || !prev_white_reg)) begin
                runs_next = (runs_reg == RUN_MAX) ? RUN_MAX : runs_reg + run_cnt_t'(1);
            end
            prev_white_next = ctrl.white;
        end
    end

    // Update on each processed item; the glyph's last pixel clears the line.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            runs_reg       <= '0;
            prev_white_reg <= 1'b0;
        end else if (ctrl.step) begin
            if (ctrl.clear) begin
                runs_reg       <= '0;
                prev_white_reg <= 1'b0;
            end else begin
                runs_reg       <= runs_next;
                prev_white_reg <= prev_white_next;
            end
        end
    end

endmodule

// ===== rtl/core/scanline_digit_classifier_core.sv =====
// Top level of the scanline digit classifier: input register, line sampling and result register.
// Depends on scd_pkg and instantiates three scd_run_counter lines.
//
//  channel | ports                       | word contents
//  --------+-----------------------------+---------------------------------------------
//  s_      | s_tvalid s_tready s_tdata   | one pixel with its coordinates and glyph size
//          | s_tlast                     | last pixel of the glyph
//  m_      | m_tvalid m_tready m_tdata   | classified character, one per glyph
//          | m_tuser                     | character was recognized
//
// One pixel word is taken per cycle while no last pixel waits on a held result; the result
// word is loaded when the last pixel leaves the input register, provided the result slot is free.
// The per-pixel work (sample positions, run tests, code lookup) sits between the
// input register and the result register, so throughput is one word per cycle when no result is held.
// Reset is synchronous on aresetn low and clears all line state; the block then
// accepts at once. A held result stalls the input only when a last pixel is waiting.

module scanline_digit_classifier_core
    import scd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] pixel, [15:8] row, [23:16] col, [32:24] glyph_width,
    // [41:33] glyph_height, [47:42] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [6:0] char_code, [7] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] recognized
    output logic                 m_tuser
);

    // Input register.
    logic               in_valid_reg;
    logic [7:0]         in_pixel_reg;
    logic [COORD_W-1:0] in_row_reg;
    logic [COORD_W-1:0] in_col_reg;
    logic [DIM_W-1:0]   in_width_reg;
    logic [DIM_W-1:0]   in_height_reg;
    logic               in_last_reg;

    // Result register.
    logic               m_valid_reg;
    logic [CHAR_W-1:0]  m_char_reg;
    logic               m_recog_reg;

    logic               s_fire;
    logic               out_free;
    logic               advance;

    // Handshake: an item moves on unless it is a last pixel facing a full result slot.
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_pixel_reg  <= s_tdata[7:0];
            in_row_reg    <= s_tdata[15:8];
            in_col_reg    <= s_tdata[23:16];
            in_width_reg  <= s_tdata[32:24];
            in_height_reg <= s_tdata[41:33];
            in_last_reg   <= s_tlast;
        end
    end

    // Sample positions from the clamped glyph size.
    logic [DIM_W-1:0]   w_cl;
    logic [DIM_W-1:0]   h_cl;
    logic [R1_PW-1:0]   r1_prod;
    logic [R2_PW-1:0]   r2_prod;
    logic [COORD_W-1:0] upper_pos;
    logic [COORD_W-1:0] lower_pos;
    logic [COORD_W-1:0] mid_pos;

    assign w_cl      = (in_width_reg  > MAX_DIM) ? MAX_DIM : in_width_reg;
    assign h_cl      = (in_height_reg > MAX_DIM) ? MAX_DIM : in_height_reg;
    assign r1_prod   = R1_PW'(h_cl) * R1_PW'(R1_MUL);
    assign r2_prod   = R2_PW'(h_cl) * R2_PW'(R2_MUL);
    assign upper_pos = r1_prod[R1_SH +: COORD_W];
    assign lower_pos = r2_prod[R2_SH +: COORD_W];
    assign mid_pos   = w_cl[DIM_W-1:1];

    // Line hits for the current pixel.
    logic white;
    logic upper_hit;
    logic lower_hit;
    logic mid_hit;

    assign white     = (in_pixel_reg == WHITE);
    assign upper_hit = (in_row_reg == upper_pos);
    assign lower_hit = (in_row_reg == lower_pos);
    assign mid_hit   = (in_col_reg == mid_pos);

    // Three run counters: two rows and the middle column.
    run_ctrl_t upper_ctrl;
    run_ctrl_t lower_ctrl;
    run_ctrl_t mid_ctrl;
    run_cnt_t  upper_runs_next;
    run_cnt_t  lower_runs_next;
    run_cnt_t  mid_runs_next;

    assign upper_ctrl = '{step: advance, hit: upper_hit, white: white,
                          line_start: (in_col_reg == '0), clear: in_last_reg};
    assign lower_ctrl = '{step: advance, hit: lower_hit, white: white,
                          line_start: (in_col_reg == '0), clear: in_last_reg};
    assign mid_ctrl   = '{step: advance, hit: mid_hit, white: white,
                          line_start: (in_row_reg == '0), clear: in_last_reg};

    scd_run_counter u_upper_runs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (upper_ctrl),
        .runs_next (upper_runs_next)
    );

    scd_run_counter u_lower_runs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (lower_ctrl),
        .runs_next (lower_runs_next)
    );

    scd_run_counter u_mid_runs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (mid_ctrl),
        .runs_next (mid_runs_next)
    );

    // First white column on each sampled row.
    logic               upper_seen_reg;
    logic               lower_seen_reg;
    logic [COORD_W-1:0] upper_first_reg;
    logic [COORD_W-1:0] lower_first_reg;
    logic               upper_seen_next;
    logic               lower_seen_next;
    logic [COORD_W-1:0] upper_first_next;
    logic [COORD_W-1:0] lower_first_next;

    always_comb begin
        upper_seen_next  = upper_seen_reg;
        upper_first_next = upper_first_reg;
        lower_seen_next  = lower_seen_reg;
        lower_first_next = lower_first_reg;
        if (upper_hit && white && !upper_seen_reg) begin
            upper_seen_next  = 1'b1;
            upper_first_next = in_col_reg;
        end
        if (lower_hit && white && !lower_seen_reg) begin
            lower_seen_next  = 1'b1;
            lower_first_next = in_col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_seen_reg  <= 1'b0;
            lower_seen_reg  <= 1'b0;
            upper_first_reg <= '0;
            lower_first_reg <= '0;
        end else if (advance) begin
            if (in_last_reg) begin
                upper_seen_reg  <= 1'b0;
                lower_seen_reg  <= 1'b0;
                upper_first_reg <= '0;
                lower_first_reg <= '0;
            end else begin
                upper_seen_reg  <= upper_seen_next;
                lower_seen_reg  <= lower_seen_next;
                upper_first_reg <= upper_first_next;
                lower_first_reg <= lower_first_next;
            end
        end
    end

    // Classification. A glyph with three column runs and one run on each row
    // is told apart by where its rows first turn white relative to the middle.
    run_cnt_t          k1;
    run_cnt_t          k2;
    logic [CHAR_W-1:0] char_next;

    always_comb begin
        k1 = upper_runs_next;
        k2 = lower_runs_next;
        if (mid_runs_next == run_cnt_t'(3) && k1 == run_cnt_t'(1)
                && k2 == run_cnt_t'(1)) begin
            if (upper_first_next > mid_pos && lower_first_next > mid_pos) begin
                k1 = run_cnt_t'(0);
                k2 = run_cnt_t'(0);
            end else if (upper_first_next < mid_pos && lower_first_next > mid_pos) begin
                k1 = run_cnt_t'(3);
                k2 = run_cnt_t'(3);
            end
        end
        char_next = scd_lookup({mid_runs_next, k1, k2});
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_char_reg  <= char_next;
            m_recog_reg <= (char_next != CH_NONE);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tuser  = m_recog_reg;

`ifndef SYNTHESIS
    // A processed last pixel always loads the result slot.
    a_last_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> m_valid_reg)
        else $error("last pixel did not produce a result");

    // The recognized flag agrees with the character code.
    a_recog_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_recog_reg == (m_char_reg != CH_NONE)))
        else $error("recognized flag disagrees with character code");

    // An empty input register never refuses a word.
    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input refused while input register empty");

    // First-white columns stay zero until a white pixel is seen on that row.
    a_first_white_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (!upper_seen_reg |-> upper_first_reg == '0)
        and (!lower_seen_reg |-> lower_first_reg == '0))
        else $error("first-white column set without a white pixel");

    // After a glyph ends, the next item starts with cleared row tracking.
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (!upper_seen_reg && !lower_seen_reg))
        else $error("row tracking not cleared after last pixel");
`endif

endmodule
